// File: src/csp_pkg.sv
// Package for the code and symbol pair bit packer.
// Holds the word types, widths and the packer result struct. No dependencies.
`default_nettype none

package csp_pkg;

	localparam int MAX_CODE_BITS = 16;
	localparam int CODE_W        = 16;
	localparam int BITS_W        = 5;
	localparam int BYTE_W        = 8;
	localparam int PEND_W        = BYTE_W - 1;
	localparam int CNT_W         = 3;
	localparam int NB_MAX        = (PEND_W + CODE_W + BYTE_W) / BYTE_W;
	localparam int NB_W          = 2;
	localparam int ACC_W         = PEND_W + CODE_W + BYTE_W;
	localparam int EFF_MAX       = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

	localparam logic ACT_PAIR  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef struct packed {
		logic              action;
		logic [CODE_W-1:0] code;
		logic [BITS_W-1:0] code_bits;
		logic [BYTE_W-1:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_last;
	} out_word_t;

	typedef struct packed {
		logic [NB_MAX*BYTE_W-1:0] bytes;
		logic [NB_W-1:0]          nbytes;
		logic [PEND_W-1:0]        pend_bits;
		logic [CNT_W-1:0]         pend_cnt;
	} pack_res_t;

endpackage

`default_nettype wire

// File: src/csp_pack.sv
// Combinational packer: merges one input word into the pending bits.
// Gives the completed bytes, their count and the new pending state. Uses csp_pkg.
`default_nettype none

module csp_pack import csp_pkg::*; (
	input  wire in_word_t          word,
	input  wire logic [PEND_W-1:0] pend_bits,
	input  wire logic [CNT_W-1:0]  pend_cnt,
	output pack_res_t              res
);

	logic [BITS_W-1:0] n;
	logic [CODE_W-1:0] code_m;
	logic [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]  rem;
	logic [BITS_W-1:0] sym_pos;
	logic [BITS_W-1:0] total;

	always_comb begin
		n = (word.code_bits > BITS_W'(EFF_MAX)) ? BITS_W'(EFF_MAX) : word.code_bits;
		for (int i = 0; i < CODE_W; i++) begin
			code_m[i] = word.code[i] & (BITS_W'(i) < n);
		end
		sym_pos = BITS_W'(pend_cnt) + n;
		acc = ACC_W'(pend_bits) | (ACC_W'(code_m) << pend_cnt)
			| (ACC_W'(word.symbol) << sym_pos);
		total = sym_pos + BITS_W'(BYTE_W);
		rem = acc >> {total[BITS_W-1:3], 3'b000};

		if (word.action == ACT_FLUSH) begin
			res.bytes     = (NB_MAX*BYTE_W)'(pend_bits);
			res.nbytes    = (pend_cnt != '0) ? NB_W'(1) : '0;
			res.pend_bits = '0;
			res.pend_cnt  = '0;
		end else begin
			res.bytes     = acc[NB_MAX*BYTE_W-1:0];
			res.nbytes    = total[BITS_W-1:3];
			res.pend_bits = rem[PEND_W-1:0];
			res.pend_cnt  = total[2:0];
		end
	end

endmodule

`default_nettype wire

// File: src/code_symbol_pair_bit_packer.sv
// Top level of the code and symbol pair bit packer.
// Uses csp_pkg and csp_pack.
//
// Each accepted pair word appends its low code_bits code bits (saturated at 16)
// and then its 8 symbol bits to the pending bit buffer, least significant bit
// first, and yields one to three bytes; a flush word yields the partial byte,
// zero padded, if any bits are pending, then clears the buffer. The last byte
// of each word has is_last set. Bytes leave one per cycle, unless out_stall
// holds them, through an output register, so an item holds the byte buffer
// until its last byte is handed over; a flush with nothing pending yields none.
// A new word is taken in the cycle its predecessor hands over its final byte.
`default_nettype none

module code_symbol_pair_bit_packer import csp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_data
);

	logic [PEND_W-1:0]        pend_bits_q;
	logic [CNT_W-1:0]         pend_cnt_q;
	logic                     valid_s1;
	logic [NB_MAX*BYTE_W-1:0] bytes_s1;
	logic [NB_W-1:0]          nb_s1;
	logic [NB_W-1:0]          idx_q;
	logic                     out_valid_q;
	out_word_t                out_data_q;

	pack_res_t res;
	logic      out_load;
	logic      hand;
	logic      s1_last;
	logic      in_acc;
	out_word_t next_out;

	csp_pack u_pack (
		.word      (in_data),
		.pend_bits (pend_bits_q),
		.pend_cnt  (pend_cnt_q),
		.res       (res)
	);

	always_comb begin
		out_load          = !out_valid_q || !out_stall;
		hand              = valid_s1 && out_load;
		s1_last           = (idx_q == nb_s1 - NB_W'(1));
		in_stall          = valid_s1 && !(hand && s1_last);
		in_acc            = in_valid && !in_stall;
		next_out.out_byte = bytes_s1[idx_q*BYTE_W +: BYTE_W];
		next_out.is_last  = s1_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				pend_bits_q <= res.pend_bits;
				pend_cnt_q  <= res.pend_cnt;
				valid_s1    <= (res.nbytes != '0);
				idx_q       <= '0;
			end else if (hand) begin
				if (s1_last) begin
					valid_s1 <= 1'b0;
				end else begin
					idx_q <= idx_q + NB_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= hand;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bytes_s1 <= res.bytes;
			nb_s1    <= res.nbytes;
		end
		if (hand) begin
			out_data_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_nb_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> nb_s1 != '0)
		else $error("byte buffer holds no bytes");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_q < nb_s1)
		else $error("byte index beyond count");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACT_FLUSH |=> pend_cnt_q == '0)
		else $error("flush left bits pending");

	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_bits_q >> pend_cnt_q) == '0)
		else $error("stray bits above pending count");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty byte buffer");

endmodule

`default_nettype wire
